// File: hw/rtl/fpsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsa_pkg
// Codes and fixed constants of the fit-policy segment allocator.
// ----------------------------------------------------------------------------
package fpsa_pkg;

   localparam int ARENA_BITS = 20;

   localparam logic [1:0] KIND_INIT  = 2'd0;
   localparam logic [1:0] KIND_ALLOC = 2'd1;
   localparam logic [1:0] KIND_FREE  = 2'd2;
   // unused kind, answered with the totals only
   localparam logic [1:0] KIND_SPARE = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOFIT   = 2'd1;
   localparam logic [1:0] ST_UNKNOWN = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;
   // unused policy, behaves as first fit
   localparam logic [1:0] FIT_SPARE = 2'd3;

   localparam logic CSR_FIT_POLICY = 1'b0;
   localparam logic CSR_ARENA_SIZE = 1'b1;

   localparam int SPLIT_MIN   = 8;
   localparam int ALIGN_MASK  = 63;
   localparam int ALIGN_BYTES = 64;
   localparam logic [20:0] ARENA_RESET = 21'd65536;

endpackage

// File: hw/rtl/fit_policy_segment_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_segment_allocator
// Free-list allocator with first, best or worst fit over a headered arena.
// ----------------------------------------------------------------------------
// Usage: a request (kind, request_size, release_offset) is taken on req_valid
// and req_ready; each request gives exactly one response on rsp_valid and
// rsp_ready carrying status, granted offset and the running byte totals.
// Hole and block tables sit in two synchronous memories (start, length);
// valid bits and list ranks sit in flops.
// Scan: init and spare kinds need no scan; allocate walks the hole and
// block tables in one pass; free finds its block, then in a second pass
// its neighbor holes and a free hole slot. The scan reads one hole entry,
// and in the first pass one block entry, per cycle via the read ports.
// One request is in work at a time; a new one is taken once the previous
// response has been loaded into the output register.
// Reset: after reset the block writes the single arena hole and
// then takes requests. Configuration writes are taken in any cycle.
// Stall: while the output register is full and not taken, the finished
// request waits before committing, and no new request is taken.
// ----------------------------------------------------------------------------
module fit_policy_segment_allocator
   import fpsa_pkg::*;
#(
   parameter int HOLE_ENTRIES  = 16,
   parameter int BLOCK_ENTRIES = 16,
   parameter int HEADER_BYTES  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [20:0] req_request_size,
   input  logic [19:0] req_release_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [19:0] rsp_granted_offset,
   output logic [20:0] rsp_free_bytes,
   output logic [20:0] rsp_used_bytes,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [20:0] csr_write_data
);

   localparam int DW  = (ARENA_BITS + 2 > 22) ? ARENA_BITS + 2 : 22;
   localparam int N   = (HOLE_ENTRIES > BLOCK_ENTRIES) ? HOLE_ENTRIES : BLOCK_ENTRIES;
   localparam int CW  = $clog2(N + 1);
   localparam int HIW = $clog2(HOLE_ENTRIES);
   localparam int BIW = $clog2(BLOCK_ENTRIES);

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN1 = 3'd2;
   localparam logic [2:0] S_SCAN2 = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   typedef struct packed {
      logic [DW-1:0] start;
      logic [DW-1:0] length;
   } seg_type;

   seg_type hole_mem [HOLE_ENTRIES];
   seg_type block_mem [BLOCK_ENTRIES];
   seg_type hole_q, block_q, hole_wd, block_wd;
   logic hole_we, block_we, hole_re, block_re;
   logic [HIW-1:0] hole_wa, hole_ra;
   logic [BIW-1:0] block_wa, block_ra;

   logic [2:0] state_ff, state_in;
   logic [1:0] kind_ff, kind_in;
   logic [DW-1:0] req_ff, req_in, rel_ff, rel_in;
   logic [1:0] fit_ff, fit_in;
   logic [20:0] arena_ff, arena_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [HOLE_ENTRIES-1:0] hvalid_ff, hvalid_in;
   logic [HIW-1:0] hrank_ff [HOLE_ENTRIES];
   logic [HIW-1:0] hrank_in [HOLE_ENTRIES];
   logic [BLOCK_ENTRIES-1:0] bvalid_ff, bvalid_in;
   logic [DW-1:0] free_ff, free_in, used_ff, used_in;

   logic pick_ok_ff, pick_ok_in;
   logic [HIW-1:0] pick_idx_ff, pick_idx_in, pick_rank_ff, pick_rank_in;
   logic [DW-1:0] pick_start_ff, pick_start_in, pick_len_ff, pick_len_in;
   logic bslot_ok_ff, bslot_ok_in;
   logic [BIW-1:0] bslot_ff, bslot_in;
   logic blk_ok_ff, blk_ok_in;
   logic [BIW-1:0] blk_idx_ff, blk_idx_in;
   logic [DW-1:0] blk_start_ff, blk_start_in, blk_len_ff, blk_len_in;
   logic rh_ok_ff, rh_ok_in, lh_ok_ff, lh_ok_in;
   logic [HIW-1:0] rh_idx_ff, rh_idx_in, rh_rank_ff, rh_rank_in;
   logic [HIW-1:0] lh_idx_ff, lh_idx_in, lh_rank_ff, lh_rank_in;
   logic [DW-1:0] rh_len_ff, rh_len_in, lh_start_ff, lh_start_in, lh_len_ff, lh_len_in;
   logic hslot_ok_ff, hslot_ok_in;
   logic [HIW-1:0] hslot_ff, hslot_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [19:0] rsp_off_ff, rsp_off_in;
   logic [20:0] rsp_free_ff, rsp_free_in, rsp_used_ff, rsp_used_in;

   logic [DW-1:0] hb, arena_bytes, round_up, cap, left, rkey, hend;
   logic [CW-1:0] e;
   logic [HIW-1:0] eh, mrank;
   logic [BIW-1:0] eb;
   logic better, eval;

   assign hb = DW'(HEADER_BYTES);
   assign cap = DW'(1) << ARENA_BITS;
   assign round_up = (DW'(arena_ff) + DW'(ALIGN_MASK)) & ~DW'(ALIGN_MASK);
   assign arena_bytes = (round_up < DW'(ALIGN_BYTES)) ? DW'(ALIGN_BYTES)
                      : (round_up > cap) ? cap : round_up;
   assign e = scan_ff - CW'(1);
   assign eh = e[HIW-1:0];
   assign eb = e[BIW-1:0];
   assign eval = (scan_ff != '0);
   assign left = pick_len_ff - req_ff;
   assign rkey = blk_start_ff + blk_len_ff + hb;
   assign hend = hole_q.start + hole_q.length + hb;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_granted_offset = rsp_off_ff;
   assign rsp_free_bytes = rsp_free_ff;
   assign rsp_used_bytes = rsp_used_ff;

   always_comb begin
      state_in = state_ff; kind_in = kind_ff; req_in = req_ff; rel_in = rel_ff;
      fit_in = fit_ff; arena_in = arena_ff; scan_in = scan_ff;
      hvalid_in = hvalid_ff; hrank_in = hrank_ff; bvalid_in = bvalid_ff;
      free_in = free_ff; used_in = used_ff;
      pick_ok_in = pick_ok_ff; pick_idx_in = pick_idx_ff; pick_rank_in = pick_rank_ff;
      pick_start_in = pick_start_ff; pick_len_in = pick_len_ff;
      bslot_ok_in = bslot_ok_ff; bslot_in = bslot_ff;
      blk_ok_in = blk_ok_ff; blk_idx_in = blk_idx_ff;
      blk_start_in = blk_start_ff; blk_len_in = blk_len_ff;
      rh_ok_in = rh_ok_ff; rh_idx_in = rh_idx_ff; rh_rank_in = rh_rank_ff; rh_len_in = rh_len_ff;
      lh_ok_in = lh_ok_ff; lh_idx_in = lh_idx_ff; lh_rank_in = lh_rank_ff;
      lh_start_in = lh_start_ff; lh_len_in = lh_len_ff;
      hslot_ok_in = hslot_ok_ff; hslot_in = hslot_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff; rsp_off_in = rsp_off_ff;
      rsp_free_in = rsp_free_ff; rsp_used_in = rsp_used_ff;
      hole_we = 1'b0; hole_wa = '0; hole_wd = '0;
      block_we = 1'b0; block_wa = '0; block_wd = '0;
      hole_re = (state_ff == S_SCAN1 || state_ff == S_SCAN2) && scan_ff < CW'(HOLE_ENTRIES);
      block_re = (state_ff == S_SCAN1) && scan_ff < CW'(BLOCK_ENTRIES);
      hole_ra = scan_ff[HIW-1:0];
      block_ra = scan_ff[BIW-1:0];
      better = 1'b0;
      mrank = hrank_ff[eh];

      if (csr_write_enable) begin
         case (csr_index)
            CSR_FIT_POLICY: fit_in = csr_write_data[1:0];
            CSR_ARENA_SIZE: arena_in = csr_write_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_INIT: begin
            hvalid_in = '0;
            hvalid_in[0] = 1'b1;
            for (int j = 0; j < HOLE_ENTRIES; j++) hrank_in[j] = '0;
            bvalid_in = '0;
            hole_we = 1'b1; hole_wa = '0;
            hole_wd.start = '0; hole_wd.length = arena_bytes;
            free_in = arena_bytes; used_in = '0;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               kind_in = req_kind;
               req_in = DW'(req_request_size);
               rel_in = DW'(req_release_offset);
               scan_in = '0;
               pick_ok_in = 1'b0; bslot_ok_in = 1'b0; blk_ok_in = 1'b0;
               rh_ok_in = 1'b0; lh_ok_in = 1'b0; hslot_ok_in = 1'b0;
               state_in = (req_kind == KIND_ALLOC || req_kind == KIND_FREE) ? S_SCAN1 : S_DONE;
            end
         end
         S_SCAN1: begin
            if (eval) begin
               if (kind_ff == KIND_ALLOC) begin
                  if (e < CW'(HOLE_ENTRIES) && hvalid_ff[eh] && hole_q.length >= req_ff) begin
                     case (fit_ff)
                        FIT_BEST: better = hole_q.length < pick_len_ff ||
                           (hole_q.length == pick_len_ff && mrank < pick_rank_ff);
                        FIT_WORST: better = hole_q.length > pick_len_ff ||
                           (hole_q.length == pick_len_ff && mrank < pick_rank_ff);
                        default: better = mrank < pick_rank_ff;
                     endcase
                     if (!pick_ok_ff || better) begin
                        pick_ok_in = 1'b1; pick_idx_in = eh; pick_rank_in = mrank;
                        pick_start_in = hole_q.start; pick_len_in = hole_q.length;
                     end
                  end
                  if (e < CW'(BLOCK_ENTRIES) && !bvalid_ff[eb] && !bslot_ok_ff) begin
                     bslot_ok_in = 1'b1; bslot_in = eb;
                  end
               end else begin
                  if (e < CW'(BLOCK_ENTRIES) && bvalid_ff[eb] && !blk_ok_ff &&
                      block_q.start == rel_ff) begin
                     blk_ok_in = 1'b1; blk_idx_in = eb;
                     blk_start_in = block_q.start; blk_len_in = block_q.length;
                  end
               end
            end
            if (scan_ff == CW'(N)) begin
               scan_in = '0;
               state_in = (kind_ff == KIND_FREE) ? S_SCAN2 : S_DONE;
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end
         S_SCAN2: begin
            if (eval && e < CW'(HOLE_ENTRIES)) begin
               if (hvalid_ff[eh]) begin
                  // right neighbor starts after our header, left one ends at ours
                  if (hole_q.start == rkey && (!rh_ok_ff || mrank < rh_rank_ff)) begin
                     rh_ok_in = 1'b1; rh_idx_in = eh; rh_rank_in = mrank;
                     rh_len_in = hole_q.length;
                  end
                  if (hend == blk_start_ff && (!lh_ok_ff || mrank < lh_rank_ff)) begin
                     lh_ok_in = 1'b1; lh_idx_in = eh; lh_rank_in = mrank;
                     lh_start_in = hole_q.start; lh_len_in = hole_q.length;
                  end
               end else if (!hslot_ok_ff) begin
                  hslot_ok_in = 1'b1; hslot_in = eh;
               end
            end
            if (scan_ff == CW'(N)) begin
               scan_in = '0;
               state_in = S_DONE;
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_status_in = ST_OK;
               rsp_off_in = '0;
               case (kind_ff)
                  KIND_INIT: begin
                     hvalid_in = '0;
                     hvalid_in[0] = 1'b1;
                     for (int j = 0; j < HOLE_ENTRIES; j++) hrank_in[j] = '0;
                     bvalid_in = '0;
                     hole_we = 1'b1; hole_wa = '0;
                     hole_wd.start = '0; hole_wd.length = arena_bytes;
                     free_in = arena_bytes; used_in = '0;
                  end
                  KIND_ALLOC: begin
                     if (!pick_ok_ff) begin
                        rsp_status_in = ST_NOFIT;
                     end else if (!bslot_ok_ff) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        rsp_off_in = pick_start_ff[19:0];
                        bvalid_in[bslot_ff] = 1'b1;
                        block_we = 1'b1; block_wa = bslot_ff;
                        block_wd.start = pick_start_ff;
                        if (left > DW'(SPLIT_MIN) && left > hb) begin
                           block_wd.length = req_ff;
                           hole_we = 1'b1; hole_wa = pick_idx_ff;
                           hole_wd.start = pick_start_ff + req_ff + hb;
                           hole_wd.length = left - hb;
                           free_in = free_ff - (req_ff + hb);
                           used_in = used_ff + req_ff;
                        end else begin
                           block_wd.length = pick_len_ff;
                           hvalid_in[pick_idx_ff] = 1'b0;
                           for (int j = 0; j < HOLE_ENTRIES; j++)
                              if (hvalid_ff[j] && hrank_ff[j] > pick_rank_ff)
                                 hrank_in[j] = hrank_ff[j] - HIW'(1);
                           free_in = free_ff - pick_len_ff;
                           used_in = used_ff + pick_len_ff;
                        end
                     end
                  end
                  KIND_FREE: begin
                     if (!blk_ok_ff) begin
                        rsp_status_in = ST_UNKNOWN;
                     end else if (rh_ok_ff || lh_ok_ff) begin
                        hole_we = 1'b1;
                        if (rh_ok_ff) begin
                           hole_wa = rh_idx_ff;
                           hole_wd.start = blk_start_ff;
                           hole_wd.length = blk_len_ff + hb + rh_len_ff;
                        end else begin
                           hole_wa = lh_idx_ff;
                           hole_wd.start = lh_start_ff;
                           hole_wd.length = lh_len_ff + hb + blk_len_ff;
                        end
                        // merged hole moves to the head of the list
                        for (int j = 0; j < HOLE_ENTRIES; j++)
                           if (hvalid_ff[j] && HIW'(j) != hole_wa &&
                               hrank_ff[j] < (rh_ok_ff ? rh_rank_ff : lh_rank_ff))
                              hrank_in[j] = hrank_ff[j] + HIW'(1);
                        hrank_in[hole_wa] = '0;
                        free_in = free_ff + blk_len_ff + hb;
                        used_in = used_ff - blk_len_ff;
                        bvalid_in[blk_idx_ff] = 1'b0;
                     end else if (hslot_ok_ff) begin
                        hole_we = 1'b1; hole_wa = hslot_ff;
                        hole_wd.start = blk_start_ff; hole_wd.length = blk_len_ff;
                        for (int j = 0; j < HOLE_ENTRIES; j++)
                           if (hvalid_ff[j]) hrank_in[j] = hrank_ff[j] + HIW'(1);
                        hvalid_in[hslot_ff] = 1'b1;
                        hrank_in[hslot_ff] = '0;
                        free_in = free_ff + blk_len_ff;
                        used_in = used_ff - blk_len_ff;
                        bvalid_in[blk_idx_ff] = 1'b0;
                     end else begin
                        rsp_status_in = ST_FULL;
                     end
                  end
                  default: ;
               endcase
               rsp_free_in = free_in[20:0];
               rsp_used_in = used_in[20:0];
               if (rsp_status_in != ST_OK) rsp_off_in = '0;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (hole_we) hole_mem[hole_wa] <= hole_wd;
      if (hole_re) hole_q <= hole_mem[hole_ra];
   end

   always_ff @(posedge clock) begin
      if (block_we) block_mem[block_wa] <= block_wd;
      if (block_re) block_q <= block_mem[block_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         fit_ff <= FIT_FIRST;
         arena_ff <= ARENA_RESET;
         scan_ff <= '0;
         hvalid_ff <= '0;
         for (int j = 0; j < HOLE_ENTRIES; j++) hrank_ff[j] <= '0;
         bvalid_ff <= '0;
         free_ff <= '0;
         used_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pick_ok_ff <= 1'b0; bslot_ok_ff <= 1'b0; blk_ok_ff <= 1'b0;
         rh_ok_ff <= 1'b0; lh_ok_ff <= 1'b0; hslot_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fit_ff <= fit_in;
         arena_ff <= arena_in;
         scan_ff <= scan_in;
         hvalid_ff <= hvalid_in;
         hrank_ff <= hrank_in;
         bvalid_ff <= bvalid_in;
         free_ff <= free_in;
         used_ff <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         pick_ok_ff <= pick_ok_in; bslot_ok_ff <= bslot_ok_in; blk_ok_ff <= blk_ok_in;
         rh_ok_ff <= rh_ok_in; lh_ok_ff <= lh_ok_in; hslot_ok_ff <= hslot_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in; req_ff <= req_in; rel_ff <= rel_in;
      pick_idx_ff <= pick_idx_in; pick_rank_ff <= pick_rank_in;
      pick_start_ff <= pick_start_in; pick_len_ff <= pick_len_in;
      bslot_ff <= bslot_in;
      blk_idx_ff <= blk_idx_in; blk_start_ff <= blk_start_in; blk_len_ff <= blk_len_in;
      rh_idx_ff <= rh_idx_in; rh_rank_ff <= rh_rank_in; rh_len_ff <= rh_len_in;
      lh_idx_ff <= lh_idx_in; lh_rank_ff <= lh_rank_in;
      lh_start_ff <= lh_start_in; lh_len_ff <= lh_len_in;
      hslot_ff <= hslot_in;
      rsp_status_ff <= rsp_status_in; rsp_off_ff <= rsp_off_in;
      rsp_free_ff <= rsp_free_in; rsp_used_ff <= rsp_used_in;
   end

endmodule
